/* rtl/core/hafr_pkg.sv */
// Types, codes and helpers shared by the hex ASCII frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package hafr_pkg;

   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int REPLY_W   = 2;
   localparam int SEEN_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NAK   = 2'd2;

   localparam logic [BYTE_W-1:0] START_RESET = 8'd10;
   localparam logic [BYTE_W-1:0] ACK_RESET   = 8'd6;
   localparam logic [BYTE_W-1:0] NAK_RESET   = 8'd21;

   localparam logic [BYTE_W-1:0] MIN_LEN    = 8'd2;
   localparam logic [BYTE_W-1:0] EMPTY_CHAR = 8'd0;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_JUNK     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_BIG  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TOO_SMALL = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM  = 3'd4;

   localparam logic [REPLY_W-1:0] REPLY_NONE = 2'd0;
   localparam logic [REPLY_W-1:0] REPLY_ACK  = 2'd1;
   localparam logic [REPLY_W-1:0] REPLY_NAK  = 2'd2;

   localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
   localparam logic [SEEN_W-1:0] SEEN_ACK  = 2'd1;
   localparam logic [SEEN_W-1:0] SEEN_NAK  = 2'd2;

   localparam logic OP_RX_BYTE = 1'b0;
   localparam logic OP_SENT    = 1'b1;

   typedef enum logic [1:0] {
      RS_AWAIT = 2'd0,
      RS_ACK   = 2'd1,
      RS_NAK   = 2'd2
   } reply_state_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_LOAD = 2'd2
   } state_type;

   function automatic logic [3:0] hex_digit(input logic [BYTE_W-1:0] ch);
      logic [3:0] d;
      d = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         d = ch[3:0];
      end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
         d = 4'(ch[2:0] + 4'd9);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/hafr_ifs.sv */
// Valid/ready channel interfaces for request, response and register write beats.
`timescale 1ns / 1ps
`default_nettype none

interface hafr_req_if import hafr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface hafr_rsp_if import hafr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [REPLY_W-1:0]  reply;
   logic [SEEN_W-1:0]   response_seen;
   logic                payload_valid;
   logic [BYTE_W-1:0]   payload_data;
   logic                last;
   modport source (output valid, output status, output reply, output response_seen,
                   output payload_valid, output payload_data, output last, input ready);
   modport sink   (input valid, input status, input reply, input response_seen,
                   input payload_valid, input payload_data, input last, output ready);
endinterface

interface hafr_csr_if import hafr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/hafr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module hafr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/hex_ascii_frame_receiver_unit.sv */
// Top level of the hex ASCII frame receiver.
//
// Every request beat gives one response beat, unless it completes a frame
// whose checksum matches: that frame's L-1 payload bytes are then read back
// out of the frame store one at a time (store read, then load into the
// response register), and no request is taken during that readout.
// The response register lets a new request in as soon as the pending response
// beat is taken. The frame store has no reset; only bytes written in the
// current frame are read back. Register writes are accepted in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module hex_ascii_frame_receiver_unit import hafr_pkg::*; #(
   parameter int MAX_LEN = 32
) (
   input  wire           clock,
   input  wire           reset,
   hafr_req_if.sink      req_bus,
   hafr_rsp_if.source    rsp_bus,
   hafr_csr_if.sink      csr_bus
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);

   state_type            state_ff, state_in;
   logic [BYTE_W-1:0]    start_ff, start_in;
   logic [BYTE_W-1:0]    ack_ff, ack_in;
   logic [BYTE_W-1:0]    nak_ff, nak_in;
   logic                 in_frame_ff, in_frame_in;
   logic                 length_known_ff, length_known_in;
   logic [LEN_W-1:0]     frame_length_ff, frame_length_in;
   logic [LEN_W-1:0]     byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]    held_ff, held_in;
   logic [BYTE_W-1:0]    sum_ff, sum_in;
   reply_state_type      reply_state_ff, reply_state_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [REPLY_W-1:0]   reply_ff, reply_in;
   logic [SEEN_W-1:0]    seen_ff, seen_in;
   logic                 pvalid_ff, pvalid_in;
   logic [BYTE_W-1:0]    pdata_ff, pdata_in;
   logic                 last_ff, last_in;

   logic                 slot_free;
   logic                 req_fire;
   logic                 good_frame;
   logic                 frame_closes;
   logic                 drain_last;
   logic [BYTE_W-1:0]    value;
   logic [LEN_W-1:0]     count_next;
   logic                 store_we;
   logic                 store_re;
   logic [BYTE_W-1:0]    store_q;

   assign slot_free       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready   = (state_ff == ST_IDLE) && slot_free;
   assign req_fire        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;

   assign value      = {hex_digit(held_ff), hex_digit(req_bus.rx_byte)};
   assign count_next = LEN_W'(byte_count_ff + LEN_W'(1));
   assign drain_last = (LEN_W'(idx_ff) + LEN_W'(2)) == frame_length_ff;

   // Classify the byte that completes a pair once the length is known.
   assign frame_closes = in_frame_ff && (held_ff != EMPTY_CHAR) && length_known_ff
                         && (count_next >= frame_length_ff);
   assign good_frame   = (req_bus.opcode == OP_RX_BYTE)
                         && (req_bus.rx_byte != start_ff)
                         && !((req_bus.rx_byte == ack_ff || req_bus.rx_byte == nak_ff)
                              && reply_state_ff == RS_AWAIT)
                         && frame_closes && (sum_ff == value);

   assign store_we = req_fire && (req_bus.opcode == OP_RX_BYTE)
                     && (req_bus.rx_byte != start_ff)
                     && !((req_bus.rx_byte == ack_ff || req_bus.rx_byte == nak_ff)
                          && reply_state_ff == RS_AWAIT)
                     && in_frame_ff && (held_ff != EMPTY_CHAR) && length_known_ff;
   assign store_re = (state_ff == ST_READ);

   // Readout starts only after the closing write, so reads never meet a write.
   hafr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (byte_count_ff[ADDR_W-1:0]),
      .wr_data (value),
      .rd_en   (store_re),
      .rd_addr (idx_ff),
      .rd_data (store_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && good_frame) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) begin
               state_in = drain_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      start_in        = start_ff;
      ack_in          = ack_ff;
      nak_in          = nak_ff;
      in_frame_in     = in_frame_ff;
      length_known_in = length_known_ff;
      frame_length_in = frame_length_ff;
      byte_count_in   = byte_count_ff;
      held_in         = held_ff;
      sum_in          = sum_ff;
      reply_state_in  = reply_state_ff;
      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      status_in       = status_ff;
      reply_in        = reply_ff;
      seen_in         = seen_ff;
      pvalid_in       = pvalid_ff;
      pdata_in        = pdata_ff;
      last_in         = last_ff;

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_START: start_in = csr_bus.data;
            CSR_ACK:   ack_in   = csr_bus.data;
            CSR_NAK:   nak_in   = csr_bus.data;
            default:   ;
         endcase
      end

      if (req_fire) begin
         rsp_valid_in = !good_frame;
         status_in    = STATUS_OK;
         reply_in     = REPLY_NONE;
         seen_in      = SEEN_NONE;
         pvalid_in    = 1'b0;
         pdata_in     = '0;
         last_in      = 1'b1;
         if (req_bus.opcode == OP_SENT) begin
            reply_state_in = RS_AWAIT;
         end else if (req_bus.rx_byte == start_ff) begin
            in_frame_in     = 1'b1;
            length_known_in = 1'b0;
            frame_length_in = '0;
            byte_count_in   = '0;
            held_in         = EMPTY_CHAR;
            sum_in          = '0;
         end else if (req_bus.rx_byte == ack_ff && reply_state_ff == RS_AWAIT) begin
            reply_state_in = RS_ACK;
            seen_in        = SEEN_ACK;
         end else if (req_bus.rx_byte == nak_ff && reply_state_ff == RS_AWAIT) begin
            reply_state_in = RS_NAK;
            seen_in        = SEEN_NAK;
         end else if (!in_frame_ff) begin
            status_in = STATUS_JUNK;
         end else if (held_ff == EMPTY_CHAR) begin
            held_in = req_bus.rx_byte;
         end else begin
            held_in = EMPTY_CHAR;
            if (!length_known_ff) begin
               if (value > 8'(MAX_LEN)) begin
                  in_frame_in = 1'b0;
                  status_in   = STATUS_TOO_BIG;
               end else if (value < MIN_LEN) begin
                  in_frame_in = 1'b0;
                  status_in   = STATUS_TOO_SMALL;
               end else begin
                  length_known_in = 1'b1;
                  frame_length_in = value[LEN_W-1:0];
                  byte_count_in   = '0;
                  sum_in          = 8'(sum_ff + value);
               end
            end else begin
               byte_count_in = count_next;
               if (frame_closes) begin
                  in_frame_in = 1'b0;
                  idx_in      = '0;
                  if (!good_frame) begin
                     status_in = STATUS_BAD_SUM;
                     reply_in  = REPLY_NAK;
                  end
               end else begin
                  sum_in = 8'(sum_ff + value);
               end
            end
         end
      end

      // Load one payload beat from the store.
      if (state_ff == ST_LOAD && slot_free) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         reply_in     = (idx_ff == '0) ? REPLY_ACK : REPLY_NONE;
         seen_in      = SEEN_NONE;
         pvalid_in    = 1'b1;
         pdata_in     = store_q;
         last_in      = drain_last;
         idx_in       = ADDR_W'(idx_ff + ADDR_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         start_ff        <= START_RESET;
         ack_ff          <= ACK_RESET;
         nak_ff          <= NAK_RESET;
         in_frame_ff     <= 1'b0;
         length_known_ff <= 1'b0;
         frame_length_ff <= '0;
         byte_count_ff   <= '0;
         held_ff         <= EMPTY_CHAR;
         sum_ff          <= '0;
         reply_state_ff  <= RS_ACK;
         idx_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         start_ff        <= start_in;
         ack_ff          <= ack_in;
         nak_ff          <= nak_in;
         in_frame_ff     <= in_frame_in;
         length_known_ff <= length_known_in;
         frame_length_ff <= frame_length_in;
         byte_count_ff   <= byte_count_in;
         held_ff         <= held_in;
         sum_ff          <= sum_in;
         reply_state_ff  <= reply_state_in;
         idx_ff          <= idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      reply_ff  <= reply_in;
      seen_ff   <= seen_in;
      pvalid_ff <= pvalid_in;
      pdata_ff  <= pdata_in;
      last_ff   <= last_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.reply         = reply_ff;
   assign rsp_bus.response_seen = seen_ff;
   assign rsp_bus.payload_valid = pvalid_ff;
   assign rsp_bus.payload_data  = pdata_ff;
   assign rsp_bus.last          = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= LEN_W'(MAX_LEN))
      else $error("byte count beyond store depth");

   a_drain_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (LEN_W'(idx_ff) + LEN_W'(1)) < frame_length_ff)
      else $error("readout index past payload");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pvalid_ff) |-> (status_ff == STATUS_OK && seen_ff == SEEN_NONE))
      else $error("payload beat carries status or reply seen");

   a_ack_with_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && reply_ff == REPLY_ACK) |-> pvalid_ff)
      else $error("ack reply without payload");

   a_no_store_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !store_we)
      else $error("store write during readout");

endmodule

`default_nettype wire
